// File: hdl/pid_controller_clamped_defines.svh
// Assertion macros shared by the checker files of the PID controller.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef PID_CONTROLLER_CLAMPED_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PIDC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PIDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pidc_pkg.sv
// Package of the clamped PID controller: types, codes and fixed-point helpers.
// No dependencies; every other file of the block but the defines header imports it.
`default_nettype none

package pidc_pkg;

  typedef logic signed [31:0] q16_t;
  typedef logic [30:0]        umag_t;
  typedef logic [2:0]         cfg_addr_t;
  typedef logic signed [32:0] mul_opd_t;
  typedef logic signed [65:0] mul_prod_t;
  typedef logic signed [33:0] wide_sum_t;

  localparam q16_t  Q16_MAX     = 32'sh7FFF_FFFF;
  localparam q16_t  Q16_MIN     = 32'sh8000_0000;
  localparam umag_t LIMIT_RESET = 31'h7FFF_FFFF;
  localparam umag_t PERIOD_RESET = 31'h0001_0000;
  localparam int    FracBits    = 16;

  // Register indexes of the configuration port.
  typedef enum cfg_addr_t {
    CFG_SETPOINT = 3'd0,
    CFG_GAIN_P   = 3'd1,
    CFG_GAIN_D   = 3'd2,
    CFG_GAIN_I   = 3'd3,
    CFG_LIMIT    = 3'd4,
    CFG_PERIOD   = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ERR, ST_DIFF, ST_MUL_P, ST_MUL_D, ST_MUL_I, ST_MUL_T,
    ST_MUL_S, ST_STEP, ST_INTEG, ST_SUM
  } ctl_state_t;

  typedef enum logic [1:0] {DIV_IDLE, DIV_LOAD, DIV_RUN} div_state_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    umag_t              den;
  } div_req_t;

  typedef struct packed {
    logic done;
    q16_t quot;
  } div_rsp_t;

  typedef struct packed {
    q16_t value;
    logic hit;
  } clamp_t;

  // Saturate a 33-bit signed value to 32 bits.
  function automatic q16_t sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      sat33 = v[32] ? Q16_MIN : Q16_MAX;
    end else begin
      sat33 = v[31:0];
    end
  endfunction

  // Q16.16 product: floor shift by the fraction width, then saturate.
  function automatic q16_t qsat(input mul_prod_t p);
    if (p[65:47] == {19{p[65]}}) begin
      qsat = p[47:FracBits];
    end else begin
      qsat = p[65] ? Q16_MIN : Q16_MAX;
    end
  endfunction

  // Symmetric clamp to plus or minus lim, with a flag when it acted.
  function automatic clamp_t clamp_lim(input wide_sum_t v, input umag_t lim);
    wide_sum_t hi;
    wide_sum_t lo;
    clamp_t    r;
    hi = {3'b000, lim};
    lo = -hi;
    if (v > hi) begin
      r.value = hi[31:0];
      r.hit   = 1'b1;
    end else if (v < lo) begin
      r.value = lo[31:0];
      r.hit   = 1'b1;
    end else begin
      r.value = v[31:0];
      r.hit   = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/pidc_if.sv
// Valid/ready channel interfaces of the PID controller: samples, results, config.
// Depends on pidc_pkg for the payload types.
`default_nettype none

interface pidc_in_if import pidc_pkg::*; ();
  logic valid;
  logic ready;
  q16_t measurement;

  modport source (output valid, output measurement, input ready);
  modport sink (input valid, input measurement, output ready);
endinterface

interface pidc_out_if import pidc_pkg::*; ();
  logic valid;
  logic ready;
  q16_t drive;
  logic saturated;

  modport source (output valid, output drive, output saturated, input ready);
  modport sink (input valid, input drive, input saturated, output ready);
endinterface

interface pidc_cfg_if import pidc_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_addr_t index;
  q16_t      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/pidc_mul.sv
// Shared signed multiplier of the PID controller with a registered product.
// Depends on pidc_pkg for operand types and the Q16.16 saturation helper.
`default_nettype none

module pidc_mul import pidc_pkg::*; (
  input  wire logic clk,
  input  wire logic en,
  input  mul_opd_t  opd_a,
  input  mul_opd_t  opd_b,
  output mul_prod_t prod,
  output q16_t      prod_q
);

  mul_prod_t prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= opd_a * opd_b;
    end
  end

  assign prod   = prod_r;
  assign prod_q = qsat(prod_r);

endmodule

`default_nettype wire

// File: hdl/pidc_div.sv
// Restoring divider for the derivative term: one quotient bit per cycle.
// Depends on pidc_pkg for the request and response structs.
`default_nettype none

module pidc_div import pidc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  div_req_t  req,
  output div_rsp_t  rsp
);

  localparam int QuotBits = 32;

  div_state_t  state_r, state_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [63:0] mag_r, mag_nxt;
  umag_t       rem_r, rem_nxt;
  umag_t       den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic        ovf_r, ovf_nxt;
  q16_t        quot_r, quot_nxt;

  logic [31:0] shifted;
  logic [31:0] trial;
  logic        qbit;
  logic [31:0] qmag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    mag_r  <= mag_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    ovf_r  <= ovf_nxt;
    quot_r <= quot_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    cnt_nxt   = cnt_r;
    mag_nxt   = mag_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    quot_nxt  = quot_r;
    shifted   = {rem_r, mag_r[31]};
    trial     = shifted - {1'b0, den_r};
    qbit      = (shifted >= {1'b0, den_r});
    qmag      = {mag_r[30:0], qbit};
    case (state_r)
      DIV_IDLE: begin
        if (req.start) begin
          neg_nxt   = req.num[63];
          mag_nxt   = req.num[63] ? 64'(-req.num) : req.num;
          den_nxt   = req.den;
          done_nxt  = 1'b0;
          state_nxt = DIV_LOAD;
        end
      end
      DIV_LOAD: begin
        // A quotient of 2^32 or more saturates whatever its low bits are.
        ovf_nxt   = (mag_r[63:32] >= {1'b0, den_r});
        rem_nxt   = mag_r[62:32];
        cnt_nxt   = '0;
        state_nxt = DIV_RUN;
      end
      DIV_RUN: begin
        rem_nxt = qbit ? trial[30:0] : shifted[30:0];
        mag_nxt = {mag_r[63:32], qmag};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(QuotBits - 1)) begin
          if (ovf_r) begin
            quot_nxt = neg_r ? Q16_MIN : Q16_MAX;
          end else if (!neg_r) begin
            quot_nxt = qmag[31] ? Q16_MAX : qmag;
          end else begin
            quot_nxt = (qmag > 32'h8000_0000) ? Q16_MIN : -qmag;
          end
          done_nxt  = 1'b1;
          state_nxt = DIV_IDLE;
        end
      end
      default: begin
        state_nxt = DIV_IDLE;
      end
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

// File: hdl/pid_controller_clamped.sv
// Clamped PID controller: top level with the sequencer, config registers and state.
// Depends on pidc_pkg, pidc_if, pidc_mul and pidc_div.
//
// The controller takes one measured Q16.16 sample per input word and returns one
// result word: the drive, clamped to plus or minus the output limit, and a flag
// that is set when that clamp acted. The error is setpoint minus measurement; the
// drive is the sum of the proportional term, the derivative term (gain times the
// change in error, divided by the sample period) and an integral that is
// accumulated as gain times error times period and itself clamped to the limit.
// A sample period of zero is taken as the smallest step. The result word is loaded
// as the sequencer returns to idle, and the input side is ready again from then on,
// so a new sample is taken only once the last item has finished. The input side
// is not ready while an item is in flight. The pace is set by the derivative
// divider, which produces one quotient bit per cycle over 32 steps after a load
// step and runs in parallel with the last two of the four passes through the shared
// multiplier. The result sits in an output register, so the next sample is taken
// while the result still waits; a finished item holds in the last step until the
// quotient is ready and the previous result has been taken. The configuration
// channel is always ready and should be written only while the block is idle;
// unknown register indexes are ignored. The previous error and the integral are
// cleared by reset only.
`default_nettype none

module pid_controller_clamped import pidc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pidc_in_if.sink     in_ch,
  pidc_out_if.source  out_ch,
  pidc_cfg_if.sink    cfg_ch
);

  // Configuration registers.
  q16_t  setpoint_r, kp_r, kd_r, ki_r;
  umag_t limit_r, period_r;

  // Sequencer and controller state.
  ctl_state_t state_r, state_nxt;
  q16_t       prev_err_r, prev_err_nxt;
  q16_t       integ_r, integ_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Working values of the item in flight.
  q16_t meas_r, meas_nxt;
  q16_t err_r, err_nxt;
  q16_t diff_r, diff_nxt;
  q16_t prop_r, prop_nxt;
  q16_t t_r, t_nxt;
  q16_t step_r, step_nxt;
  q16_t drive_r, drive_nxt;
  logic sat_r, sat_nxt;

  umag_t              dt_eff;
  logic signed [32:0] err_wide;
  logic signed [32:0] diff_wide;
  logic signed [32:0] integ_wide;
  wide_sum_t          integ_ext;
  wide_sum_t          total;
  clamp_t             integ_cl;
  clamp_t             drive_cl;

  logic      mul_en;
  mul_opd_t  mul_a, mul_b;
  mul_prod_t mul_prod;
  q16_t      mul_q;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  pidc_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .opd_a  (mul_a),
    .opd_b  (mul_b),
    .prod   (mul_prod),
    .prod_q (mul_q)
  );

  pidc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration writes land directly; the port never stalls.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      kp_r       <= '0;
      kd_r       <= '0;
      ki_r       <= '0;
      limit_r    <= LIMIT_RESET;
      period_r   <= PERIOD_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_SETPOINT: setpoint_r <= cfg_ch.data;
        CFG_GAIN_P:   kp_r       <= cfg_ch.data;
        CFG_GAIN_D:   kd_r       <= cfg_ch.data;
        CFG_GAIN_I:   ki_r       <= cfg_ch.data;
        CFG_LIMIT:    limit_r    <= cfg_ch.data[30:0];
        CFG_PERIOD:   period_r   <= cfg_ch.data[30:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_err_r  <= '0;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_err_r  <= prev_err_nxt;
      integ_r     <= integ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meas_r  <= meas_nxt;
    err_r   <= err_nxt;
    diff_r  <= diff_nxt;
    prop_r  <= prop_nxt;
    t_r     <= t_nxt;
    step_r  <= step_nxt;
    drive_r <= drive_nxt;
    sat_r   <= sat_nxt;
  end

  assign dt_eff     = (period_r == '0) ? umag_t'(1) : period_r;
  assign err_wide   = {setpoint_r[31], setpoint_r} - {meas_r[31], meas_r};
  assign diff_wide  = {err_r[31], err_r} - {prev_err_r[31], prev_err_r};
  assign integ_wide = {integ_r[31], integ_r} + {step_r[31], step_r};
  assign integ_ext  = {{2{integ_wide[32]}}, sat33(integ_wide)};
  assign integ_cl   = clamp_lim(integ_ext, limit_r);
  assign total      = {{2{prop_r[31]}}, prop_r} + {{2{div_rsp.quot[31]}}, div_rsp.quot}
                    + {{2{integ_r[31]}}, integ_r};
  assign drive_cl   = clamp_lim(total, limit_r);

  // The sequencer: each multiply state hands one operand pair to the shared
  // multiplier, and the state after it takes the product.
  always_comb begin
    state_nxt     = state_r;
    prev_err_nxt  = prev_err_r;
    integ_nxt     = integ_r;
    out_valid_nxt = out_valid_r;
    meas_nxt      = meas_r;
    err_nxt       = err_r;
    diff_nxt      = diff_r;
    prop_nxt      = prop_r;
    t_nxt         = t_r;
    step_nxt      = step_r;
    drive_nxt     = drive_r;
    sat_nxt       = sat_r;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.num   = mul_prod[63:0];
    div_req.den   = dt_eff;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          meas_nxt  = in_ch.measurement;
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: begin
        err_nxt   = sat33(err_wide);
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        diff_nxt  = sat33(diff_wide);
        state_nxt = ST_MUL_P;
      end
      ST_MUL_P: begin
        mul_en    = 1'b1;
        mul_a     = {kp_r[31], kp_r};
        mul_b     = {err_r[31], err_r};
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        prop_nxt  = mul_q;
        mul_en    = 1'b1;
        mul_a     = {kd_r[31], kd_r};
        mul_b     = {diff_r[31], diff_r};
        state_nxt = ST_MUL_I;
      end
      ST_MUL_I: begin
        // The exact derivative product goes to the divider here.
        div_req.start = 1'b1;
        mul_en        = 1'b1;
        mul_a         = {ki_r[31], ki_r};
        mul_b         = {err_r[31], err_r};
        state_nxt     = ST_MUL_T;
      end
      ST_MUL_T: begin
        t_nxt     = mul_q;
        state_nxt = ST_MUL_S;
      end
      ST_MUL_S: begin
        mul_en    = 1'b1;
        mul_a     = {t_r[31], t_r};
        mul_b     = {2'b00, dt_eff};
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        step_nxt  = mul_q;
        state_nxt = ST_INTEG;
      end
      ST_INTEG: begin
        integ_nxt = integ_cl.value;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        // Wait for the quotient and for room in the output register.
        if (div_rsp.done && (!out_valid_r || out_ch.ready)) begin
          drive_nxt     = drive_cl.value;
          sat_nxt       = drive_cl.hit;
          out_valid_nxt = 1'b1;
          prev_err_nxt  = err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.drive     = drive_r;
  assign out_ch.saturated = sat_r;

endmodule

`default_nettype wire

// File: hdl/pidc_chk.sv
// Port-level checker of the clamped PID controller, bound to the top level.
// Depends on pidc_pkg and the assertion macros in the defines header.
`default_nettype none
`include "pid_controller_clamped_defines.svh"

module pidc_chk import pidc_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input q16_t      out_drive,
  input wire logic out_saturated
);

  // Once a sample is taken the block is busy with it.
  `PIDC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  // A result is loaded only as the sequencer returns to idle.
  `PIDC_ASSERT_SAME(a_result_at_idle, $rose(out_valid), in_ready, "result without idle")

  // The clamp is symmetric, so the most negative code can never appear.
  `PIDC_ASSERT_SAME(a_drive_symmetric, out_valid, out_drive != Q16_MIN, "drive off range")

  // A result that is not taken holds its word.
  `PIDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_drive) && $stable(out_saturated), "result changed")

endmodule

bind pid_controller_clamped pidc_chk u_pidc_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_drive     (out_ch.drive),
  .out_saturated (out_ch.saturated)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the clamped PID controller.
// Needs pidc_pkg, the pidc_if channel interfaces and the pid_controller_clamped RTL.
// A predictor in Q16.16 fixed point follows every sample word; results are checked in order.

module tb_top;
  import pidc_pkg::*;

  // Register indexes with no register behind them; writes to these must be ignored.
  localparam cfg_addr_t CFG_SPARE_6 = 3'd6;
  localparam cfg_addr_t CFG_SPARE_7 = 3'd7;

  // Longest run of cycles without any handshake before the run is declared hung.
  // A correct block with sender gaps and receiver stalls stays far below it.
  localparam int HangLimit = 3000;
  // Cycles allowed after the last result for stray words to show up.
  localparam int DrainCycles = 50;

  typedef struct {
    q16_t drive;
    logic saturated;
  } drive_word_t;

  logic clk;
  logic rst_n;

  pidc_in_if  in_ch();
  pidc_out_if out_ch();
  pidc_cfg_if cfg_ch();

  pid_controller_clamped dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the configuration registers, updated when a write is accepted.
  q16_t  setpoint_q   = '0;
  q16_t  kp_q         = '0;
  q16_t  kd_q         = '0;
  q16_t  ki_q         = '0;
  umag_t limit_q      = LIMIT_RESET;
  umag_t period_q     = PERIOD_RESET;

  // Controller state as the predictor sees it: previous error and the integral.
  longint err_prev     = 0;
  longint integral_acc = 0;

  // Expected result words, oldest first.
  drive_word_t drive_expected[$];

  int mismatch_count = 0;
  int burst_left     = 0;
  int quiet_cycles   = 0;
  int stall_cycle    = 0;
  int stall_mode     = 0;

  // ---------------------------------------------------------------------------
  // Fixed-point predictor. All intermediate values are held in 64 bits, which is
  // enough for every exact product of two 32-bit operands.
  // ---------------------------------------------------------------------------

  function automatic longint sat_s32(input longint x);
    if (x > longint'(Q16_MAX)) return longint'(Q16_MAX);
    if (x < longint'(Q16_MIN)) return longint'(Q16_MIN);
    return x;
  endfunction

  // Q16.16 product: exact, then shifted down with rounding toward minus infinity.
  function automatic longint q_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return sat_s32(p >>> FracBits);
  endfunction

  function automatic longint clamp_mag(input longint v, input longint lim, output logic hit);
    hit = 1'b1;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    hit = 1'b0;
    return v;
  endfunction

  // Advances the controller state by one sample and returns the result word.
  function automatic void pid_predict(input q16_t meas, output drive_word_t word);
    longint dt, lim, err, prop, diff, deriv, integ_step, total;
    logic   integ_hit, drive_hit;
    // A zero period is taken as the smallest step so the divide stays defined.
    dt  = (period_q == '0) ? 64'sd1 : longint'({33'd0, period_q});
    lim = longint'({33'd0, limit_q});
    err  = sat_s32(longint'(setpoint_q) - longint'(meas));
    prop = q_mul(longint'(kp_q), err);
    // The derivative keeps the full Q32.32 product and divides it by the period,
    // truncating toward zero.
    diff  = sat_s32(err - err_prev);
    deriv = sat_s32((longint'(kd_q) * diff) / dt);
    // The integral grows by gain times error times period and is held inside the
    // limit itself, which is what keeps it from winding up.
    integ_step   = q_mul(q_mul(longint'(ki_q), err), dt);
    integral_acc = clamp_mag(sat_s32(integral_acc + integ_step), lim, integ_hit);
    err_prev     = err;
    // Only the clamp on the final sum drives the flag; with a zero limit the flag
    // tells whether the unclamped sum was nonzero.
    total          = prop + deriv + integral_acc;
    word.drive     = q16_t'(clamp_mag(total, lim, drive_hit));
    word.saturated = drive_hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Random values spread over all magnitudes, with the two extremes mixed in, so
  // that both tiny and saturating operands turn up.
  // ---------------------------------------------------------------------------

  function automatic q16_t rand_q16();
    int unsigned width;
    logic [31:0] raw;
    width = $urandom_range(1, 31);
    raw   = $urandom;
    case ($urandom_range(0, 9))
      0: return Q16_MAX;
      1: return Q16_MIN;
      2, 3: return raw;
      default: begin
        raw = raw & ((32'h1 << width) - 32'h1);
        if ($urandom_range(0, 1) == 1) begin
          raw = -raw;
        end
        return raw;
      end
    endcase
  endfunction

  // A positive magnitude for the limit and period registers. Bit 31 of the data
  // word is set at random because the block must drop it.
  function automatic q16_t rand_mag();
    int unsigned width;
    logic [31:0] raw;
    width = $urandom_range(1, 31);
    raw   = $urandom & ((32'h1 << width) - 32'h1);
    raw[31] = 1'($urandom_range(0, 1));
    return raw;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers.
  // ---------------------------------------------------------------------------

  // Sends one sample word. The sender works in bursts: when a burst is used up it
  // drops valid for a random gap before the next word. Valid is left high after
  // the handshake so back-to-back words within a burst never toggle it.
  task automatic send_sample(input q16_t meas);
    drive_word_t want;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 6);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.measurement <= meas;
    do @(posedge clk); while (!in_ch.ready);
    pid_predict(meas, want);
    drive_expected.push_back(want);
  endtask

  // Writes one register and mirrors it in the shadow copy. Valid stays high so a
  // run of writes needs no toggling; finish_config lowers it afterwards.
  task automatic write_reg(input cfg_addr_t idx, input q16_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_SETPOINT: setpoint_q = value;
      CFG_GAIN_P:   kp_q       = value;
      CFG_GAIN_D:   kd_q       = value;
      CFG_GAIN_I:   ki_q       = value;
      CFG_LIMIT:    limit_q    = value[30:0];
      CFG_PERIOD:   period_q   = value[30:0];
      default: ;
    endcase
  endtask

  task automatic finish_config();
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops sending and waits until every expected result has come back, so that
  // the block is idle and registers may be written.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (drive_expected.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // With the reset configuration all gains are zero, so every drive must be zero
  // whatever the measurement.
  task automatic test_reset_config();
    send_sample(Q16_MIN);
    send_sample(Q16_MAX);
    send_sample('0);
    send_sample(32'shFFFF_FFFF);
  endtask

  // Errors and products at the edges of the 32-bit range: every saturation path.
  task automatic test_saturation_extremes();
    settle();
    write_reg(CFG_SETPOINT, Q16_MAX);
    write_reg(CFG_GAIN_P, Q16_MIN);
    write_reg(CFG_GAIN_D, Q16_MAX);
    write_reg(CFG_GAIN_I, Q16_MAX);
    write_reg(CFG_LIMIT, {1'b0, LIMIT_RESET});
    write_reg(CFG_PERIOD, {1'b0, PERIOD_RESET});
    finish_config();
    send_sample(Q16_MIN);
    send_sample(Q16_MAX);
    send_sample(Q16_MIN);
    send_sample('0);
    settle();
    // Bit 31 of the period word is dropped, which leaves the largest period.
    write_reg(CFG_PERIOD, 32'hFFFF_FFFF);
    write_reg(CFG_SETPOINT, Q16_MIN);
    write_reg(CFG_GAIN_P, Q16_MAX);
    write_reg(CFG_GAIN_D, Q16_MIN);
    finish_config();
    send_sample(Q16_MAX);
    send_sample(Q16_MIN);
  endtask

  // A zero period behaves as the smallest step; a zero limit forces the drive and
  // the integral to zero. Writes to indexes without a register must change nothing.
  task automatic test_zero_period_and_limit();
    settle();
    write_reg(CFG_SETPOINT, 32'sh0003_0000);
    write_reg(CFG_GAIN_P, 32'sh0001_0000);
    write_reg(CFG_GAIN_D, 32'sh0002_0000);
    write_reg(CFG_GAIN_I, 32'sh0000_8000);
    write_reg(CFG_PERIOD, '0);
    write_reg(CFG_LIMIT, '0);
    finish_config();
    send_sample('0);
    send_sample(32'sh0003_0000);
    send_sample(32'sh0003_0000);
    settle();
    // Only bit 31 set: the limit stays zero.
    write_reg(CFG_LIMIT, 32'h8000_0000);
    write_reg(CFG_SPARE_6, 32'h1234_5678);
    write_reg(CFG_SPARE_7, 32'hFFFF_FFFF);
    finish_config();
    send_sample(32'shFFFE_0000);
    send_sample(32'sh0003_0000);
    settle();
    write_reg(CFG_LIMIT, 32'h000A_0000);
    finish_config();
    send_sample(32'sh7000_0000);
    send_sample(32'shF000_0000);
    send_sample(32'sh0003_0000);
  endtask

  // A steady error winds the integral up to the limit, where it must stop; an
  // error of the other sign then winds it straight back down.
  task automatic test_integral_clamp();
    settle();
    write_reg(CFG_SETPOINT, '0);
    write_reg(CFG_GAIN_P, '0);
    write_reg(CFG_GAIN_D, '0);
    write_reg(CFG_GAIN_I, 32'sh0001_0000);
    write_reg(CFG_PERIOD, 32'sh0001_0000);
    write_reg(CFG_LIMIT, 32'sh0004_0000);
    finish_config();
    repeat (5) send_sample(32'shFFFF_0000);
    repeat (2) send_sample(32'sh0001_0000);
  endtask

  // Random configurations, each followed by a run of samples. Most samples sit
  // near the setpoint; the rest span the whole range.
  task automatic test_random_settings();
    int n;
    int offset;
    for (int round = 0; round < 9; round++) begin
      settle();
      write_reg(CFG_SETPOINT, rand_q16());
      write_reg(CFG_GAIN_P, rand_q16());
      write_reg(CFG_GAIN_D, rand_q16());
      write_reg(CFG_GAIN_I, rand_q16());
      case ($urandom_range(0, 7))
        0: write_reg(CFG_LIMIT, '0);
        1: write_reg(CFG_LIMIT, 32'hFFFF_FFFF);
        default: write_reg(CFG_LIMIT, rand_mag());
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(CFG_PERIOD, '0);
        1: write_reg(CFG_PERIOD, 32'h0000_0001);
        2: write_reg(CFG_PERIOD, {1'b0, PERIOD_RESET});
        default: write_reg(CFG_PERIOD, rand_mag());
      endcase
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, $urandom);
      end
      finish_config();
      n = $urandom_range(40, 56);
      repeat (n) begin
        if ($urandom_range(0, 9) < 6) begin
          offset = int'($urandom_range(0, 2097152)) - 1048576;
          send_sample(q16_t'(sat_s32(longint'(setpoint_q) + offset)));
        end else begin
          send_sample(rand_q16());
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver. Ready follows a pattern that is picked anew at random:
  // always ready, mostly ready, rarely ready, or a fixed on/off rhythm.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    stall_cycle++;
    if (stall_cycle % 256 == 0) begin
      stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 15) == 0);
      default: out_ch.ready <= ((stall_cycle / 32) % 4 != 0);
    endcase
  end

  // Each accepted result word is compared with the oldest expectation.
  always @(posedge clk) begin
    drive_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (drive_expected.size() == 0) begin
        $display("%0t: result word with nothing expected: drive %h saturated %b",
                 $time, out_ch.drive, out_ch.saturated);
        mismatch_count++;
      end else begin
        want = drive_expected.pop_front();
        if (out_ch.drive !== want.drive) begin
          $display("%0t: drive mismatch: expected %h, actual %h",
                   $time, want.drive, out_ch.drive);
          mismatch_count++;
        end
        if (out_ch.saturated !== want.saturated) begin
          $display("%0t: saturated mismatch: expected %b, actual %b",
                   $time, want.saturated, out_ch.saturated);
          mismatch_count++;
        end
      end
    end
  end

  // Hang detection: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HangLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, HangLimit, drive_expected.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run.
  // ---------------------------------------------------------------------------

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.measurement = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_config();
    test_saturation_extremes();
    test_zero_period_and_limit();
    test_integral_clamp();
    test_random_settings();

    // Everything is sent; wait for the last results, then a little longer so a
    // stray extra word would still be caught.
    settle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
